// ----- sv/phash_pkg.sv -----
// ----------------------------------------------------------------------------
// Pearson hash package
// Shared constants, item codes and structures of the 64-bit Pearson hash.
// ----------------------------------------------------------------------------
package phash_pkg;

  // Number of active lanes; the digest always carries room for eight.
  localparam int LANES     = 8;
  localparam int MAX_LANES = 8;
  localparam int BYTE_W    = 8;
  localparam int DIGEST_W  = MAX_LANES * BYTE_W;

  // Depth of the queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  // Item kinds, decided by the front.
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SEED   = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;

  // One classified word held in the queue.
  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] key;    // table index or message byte
    logic [BYTE_W-1:0] value;  // table value for a table write
    logic              last;   // ends a message
  } q_item_t;

  // Head of the queue as seen by the back.
  typedef struct packed {
    logic    valid;
    q_item_t item;
    logic [QCW-1:0] count;
  } q_port_t;

  // Status of the back.
  typedef struct packed {
    logic pop;
    logic pending;
  } back_stat_t;

endpackage

// ----- sv/pearson_hash_64.sv -----
// ----------------------------------------------------------------------------
// 64-bit Pearson hash
// Eight byte lanes, per-lane permutation tables, one byte a cycle unless held.
// ----------------------------------------------------------------------------
//
//   channel  handshake           payload
//   -------  ------------------  ----------------------------------------------
//   input    in_valid, in_stall  mode, table_index, table_value, data_byte,
//                                first_byte, last_byte
//   output   out_valid, out_stall digest
//
// One word (table write or message byte) is taken per cycle while the queue is
// not full; the lane loop is a single registered table read per lane, fed back
// into the next address. A digest is loaded from the lanes into the output
// register once its last byte has left the queue and the output is free.
// Reset clears the queue, the lanes and the output; table contents are not
// cleared and must be written before use.
// An output stall holds the back only while a second digest is waiting; the
// four-word queue keeps accepting input until it fills.
module pearson_hash_64 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [phash_pkg::BYTE_W-1:0]   table_index,
  input  logic [phash_pkg::BYTE_W-1:0]   table_value,
  input  logic [phash_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          first_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [phash_pkg::DIGEST_W-1:0] digest
);
  import phash_pkg::*;

  q_port_t    q;
  back_stat_t stat;

  phash_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .table_index (table_index),
    .table_value (table_value),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .last_byte   (last_byte),
    .pop         (stat.pop),
    .q           (q)
  );

  phash_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q         (q),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digest    (digest)
  );

  // The back never takes a word from an empty queue.
  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    stat.pop |-> q.valid)
    else $error("pop from empty queue");

  // The queue never holds more words than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q.count <= QCW'(QDEPTH))
    else $error("queue overfilled");

  // A last byte taken by the back leaves a digest pending.
  a_last_pends: assert property (@(posedge clk) disable iff (rst)
    stat.pop && (q.item.kind != KIND_WRITE) && q.item.last |=> stat.pending)
    else $error("last byte did not raise pending digest");

  // A new digest is only presented from a pending one.
  a_out_from_pending: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(stat.pending))
    else $error("digest without pending lanes");

endmodule

// ----- sv/phash_front.sv -----
// ----------------------------------------------------------------------------
// Pearson hash front
// Accepts input words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module phash_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [phash_pkg::BYTE_W-1:0] table_index,
  input  logic [phash_pkg::BYTE_W-1:0] table_value,
  input  logic [phash_pkg::BYTE_W-1:0] data_byte,
  input  logic                        first_byte,
  input  logic                        last_byte,
  input  logic                        pop,
  output phash_pkg::q_port_t          q
);
  import phash_pkg::*;

  q_item_t        entry [QDEPTH];
  q_item_t        item_in;
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QCW-1:0] count;
  logic [QCW-1:0] count_next;
  logic           push;

  // Classify the incoming word.
  always_comb begin
    if (!mode) begin
      item_in.kind = KIND_WRITE;
    end else if (first_byte) begin
      item_in.kind = KIND_SEED;
    end else begin
      item_in.kind = KIND_UPDATE;
    end
    item_in.key   = mode ? data_byte : table_index;
    item_in.value = table_value;
    item_in.last  = mode & last_byte;
  end

  // The queue stalls the input only when it is full.
  assign in_stall = (count == QCW'(QDEPTH));
  assign push     = in_valid && !in_stall;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCW'(1);
    end else if (pop && !push) begin
      count_next = count - QCW'(1);
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QAW'(1);
      end
      if (pop) begin
        rptr <= rptr + QAW'(1);
      end
      count <= count_next;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= item_in;
    end
  end

  assign q.valid = (count != '0);
  assign q.item  = entry[rptr];
  assign q.count = count;

endmodule

// ----- sv/phash_back.sv -----
// ----------------------------------------------------------------------------
// Pearson hash back
// Per-lane permutation tables, lane registers and the digest output register.
// ----------------------------------------------------------------------------
module phash_back (
  input  logic                          clk,
  input  logic                          rst,
  input  phash_pkg::q_port_t            q,
  output phash_pkg::back_stat_t         stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [phash_pkg::DIGEST_W-1:0] digest
);
  import phash_pkg::*;

  logic [BYTE_W-1:0]   lane [LANES];
  logic [DIGEST_W-1:0] packed_lanes;
  logic                pending;
  logic                take;
  logic                block;
  logic                pop;
  logic                wr_en;
  logic                hash_en;
  logic                is_seed;

  // A digest waiting in the lanes holds the back until the output frees up.
  assign take    = pending && (!out_valid || !out_stall);
  assign block   = pending && !take;
  assign pop     = q.valid && !block;
  assign wr_en   = pop && (q.item.kind == KIND_WRITE);
  assign hash_en = pop && (q.item.kind != KIND_WRITE);
  assign is_seed = (q.item.kind == KIND_SEED);

  // Each lane has its own copy of the table; all copies take every write.
  // The registered read data is the lane value itself.
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic [BYTE_W-1:0] perm_mem [2**BYTE_W];
    logic [BYTE_W-1:0] addr;

    assign addr = is_seed ? (q.item.key + BYTE_W'(j)) : (lane[j] ^ q.item.key);

    always_ff @(posedge clk) begin
      if (wr_en) begin
        perm_mem[q.item.key] <= q.item.value;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        lane[j] <= '0;
      end else if (hash_en) begin
        lane[j] <= perm_mem[addr];
      end
    end
  end

  // Pack the lanes; unused lane positions read as zero.
  for (genvar j = 0; j < MAX_LANES; j++) begin : g_pack
    if (j < LANES) begin : g_on
      assign packed_lanes[j*BYTE_W +: BYTE_W] = lane[j];
    end else begin : g_off
      assign packed_lanes[j*BYTE_W +: BYTE_W] = '0;
    end
  end

  // Digest pending flag and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (hash_en && q.item.last) begin
        pending <= 1'b1;
      end else if (take) begin
        pending <= 1'b0;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      digest <= packed_lanes;
    end
  end

  assign stat.pop     = pop;
  assign stat.pending = pending;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pearson hash 64 testbench
// Loads the permutation table, walks a short table of directed words, then
// drives random messages, table rewrites and stray bytes with bursty input and
// random output stalls. Digests are checked by a lane predictor or typed value.
// ----------------------------------------------------------------------------
module tb;
  import phash_pkg::*;

  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_HASH    = 1'b1;
  localparam int   TOTAL_WORDS  = 900;
  localparam int   IDLE_LIMIT   = 2000;
  localparam int   TAIL_CYCLES  = 32;

  // One input word as driven on the ports.
  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] idx;
    logic [BYTE_W-1:0] val;
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
  } word_t;

  // A stimulus row; a typed digest overrides the predictor when has_exp is set.
  typedef struct packed {
    word_t               w;
    logic                has_exp;
    logic [DIGEST_W-1:0] exp;
  } row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                mode;
  logic [BYTE_W-1:0]   table_index;
  logic [BYTE_W-1:0]   table_value;
  logic [BYTE_W-1:0]   data_byte;
  logic                first_byte;
  logic                last_byte;
  logic                out_valid;
  logic                out_stall;
  logic [DIGEST_W-1:0] digest;

  // Predictor state and the digests still owed by the block.
  logic [BYTE_W-1:0]   perm_model [256];
  logic [DIGEST_W-1:0] lanes_model;
  logic [DIGEST_W-1:0] pending_digests [$];
  logic [DIGEST_W-1:0] exp_digest;
  row_t                directed_rows [$];

  int errors;
  int words_sent;
  int burst_left;
  bit gaps_on;
  int idle_cycles;
  int stall_pct;
  int stall_phase_left;

  pearson_hash_64 dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .table_index (table_index),
    .table_value (table_value),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest      (digest)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random byte and random flag at the port widths.
  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic row_t row(input logic m, input logic [BYTE_W-1:0] i,
                               input logic [BYTE_W-1:0] v, input logic [BYTE_W-1:0] dat,
                               input logic f, input logic l, input logic he,
                               input logic [DIGEST_W-1:0] e);
    row_t r;
    r.w.mode  = m;
    r.w.idx   = i;
    r.w.val   = v;
    r.w.data  = dat;
    r.w.first = f;
    r.w.last  = l;
    r.has_exp = he;
    r.exp     = e;
    return r;
  endfunction

  // Applies one accepted word to the predicted table and lanes.
  // Returns 1 when the word ends a message, with the digest in d.
  function automatic logic advance_lanes(input word_t w, output logic [DIGEST_W-1:0] d);
    logic [DIGEST_W-1:0] nxt;
    logic [BYTE_W-1:0]   addr;
    nxt = '0;
    d   = '0;
    if (w.mode == MODE_WRITE) begin
      perm_model[w.idx] = w.val;
      return 1'b0;
    end
    for (int j = 0; j < LANES; j++) begin
      // A first byte seeds lane j from byte + j; later bytes chain each lane.
      if (w.first)
        addr = w.data + BYTE_W'(j);
      else
        addr = lanes_model[BYTE_W*j +: BYTE_W] ^ w.data;
      nxt[BYTE_W*j +: BYTE_W] = perm_model[addr];
    end
    lanes_model = nxt;
    d = nxt;
    return w.last;
  endfunction

  // Drives one word at the falling edge and holds it until it is taken.
  task automatic send_word(input row_t r);
    logic [DIGEST_W-1:0] d;
    @(negedge clk);
    in_valid    <= 1'b1;
    mode        <= r.w.mode;
    table_index <= r.w.idx;
    table_value <= r.w.val;
    data_byte   <= r.w.data;
    first_byte  <= r.w.first;
    last_byte   <= r.w.last;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (advance_lanes(r.w, d))
      pending_digests.push_back(r.has_exp ? r.exp : d);
    words_sent++;
    // Burst control: after a burst, drop valid for a random gap.
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(0, 24);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Holds the input side off until every owed digest has come out.
  task automatic drain_digests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall density changes from phase to phase, including no stalls.
  initial begin
    stall_pct        = 0;
    stall_phase_left = 0;
    forever begin
      @(negedge clk);
      if (stall_phase_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        stall_phase_left = $urandom_range(20, 150);
      end
      stall_phase_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Digest checker: each accepted digest is matched against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_digests.size() == 0) begin
        $display("%0t: unexpected digest: expected none, actual %h", $time, digest);
        errors++;
      end else begin
        exp_digest = pending_digests.pop_front();
        if (exp_digest !== digest) begin
          $display("%0t: digest mismatch: expected %h, actual %h", $time, exp_digest, digest);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] shuffle [256];
    logic [BYTE_W-1:0] tmp;
    int k;
    int len;
    int pick;

    rst         = 1'b1;
    in_valid    = 1'b0;
    out_stall   = 1'b0;
    mode        = MODE_WRITE;
    table_index = '0;
    table_value = '0;
    data_byte   = '0;
    first_byte  = 1'b0;
    last_byte   = 1'b0;
    errors      = 0;
    words_sent  = 0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    idle_cycles = 0;
    lanes_model = '0;
    for (int i = 0; i < 256; i++) perm_model[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Identity table, so the directed digests can be read off by eye.
    for (int i = 0; i < 256; i++)
      send_word(row(MODE_WRITE, BYTE_W'(i), BYTE_W'(i), rand_byte(), 1'b1, 1'b1,
                    1'b0, '0));

    // Directed words: mode, index, value, byte, first, last, typed?, digest.
    // A byte with no message started chains from the cleared lanes.
    directed_rows.push_back(row(MODE_HASH, 8'h00, 8'h00, 8'h5A, 1'b0, 1'b1, 1'b1,
                                64'h5A5A5A5A5A5A5A5A));
    // One-byte messages: the digest is the seeds, wrapping past 0xFF.
    directed_rows.push_back(row(MODE_HASH, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b1,
                                64'h0706050403020100));
    directed_rows.push_back(row(MODE_HASH, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1,
                                64'h06050403020100FF));
    directed_rows.push_back(row(MODE_HASH, 8'hA5, 8'h5A, 8'hFC, 1'b1, 1'b1, 1'b1,
                                64'h03020100FFFEFDFC));
    // Two-byte message.
    directed_rows.push_back(row(MODE_HASH, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(MODE_HASH, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 1'b1,
                                64'hF8F9FAFBFCFDFEFF));
    // Lanes hold after a digest; a stray byte continues from them.
    directed_rows.push_back(row(MODE_HASH, 8'h00, 8'h00, 8'h0F, 1'b0, 1'b1, 1'b1,
                                64'hF7F6F5F4F3F2F1F0));
    // Table writes at both ends; the byte and flags are ignored.
    directed_rows.push_back(row(MODE_WRITE, 8'h00, 8'hFF, 8'hA5, 1'b1, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(MODE_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(MODE_HASH, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b1,
                                64'h07060504030201FF));
    directed_rows.push_back(row(MODE_HASH, 8'h00, 8'h00, 8'hF9, 1'b1, 1'b1, 1'b1,
                                64'hFF00FEFDFCFBFAF9));
    // Longer messages after a rewrite, left to the predictor.
    directed_rows.push_back(row(MODE_WRITE, 8'h80, 8'h3C, 8'h00, 1'b0, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(MODE_HASH, 8'h00, 8'h00, 8'h80, 1'b1, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(MODE_HASH, 8'h00, 8'h00, 8'h55, 1'b0, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(MODE_HASH, 8'h00, 8'h00, 8'hAA, 1'b0, 1'b1, 1'b0, '0));
    directed_rows.push_back(row(MODE_HASH, 8'h00, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0, '0));
    directed_rows.push_back(row(MODE_HASH, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0, '0));
    foreach (directed_rows[i]) send_word(directed_rows[i]);

    // Let everything owed come out before the random part.
    drain_digests();

    // Random permutation for the random part.
    for (int i = 0; i < 256; i++) shuffle[i] = BYTE_W'(i);
    for (int i = 255; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = shuffle[i];
      shuffle[i] = shuffle[k];
      shuffle[k] = tmp;
    end
    for (int i = 0; i < 256; i++)
      send_word(row(MODE_WRITE, BYTE_W'(i), shuffle[i], rand_byte(),
                    rand_bit(), rand_bit(), 1'b0, '0));

    // Random part: mostly whole messages, some rewrites, stray and cut-off bytes.
    while (words_sent < TOTAL_WORDS) begin
      if ($urandom_range(0, 29) == 0) gaps_on = ~gaps_on;
      if ($urandom_range(0, 149) == 0) drain_digests();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int b = 0; b < len; b++)
          send_word(row(MODE_HASH, rand_byte(), rand_byte(),
                        rand_byte(), b == 0, b == len - 1, 1'b0, '0));
      end else if (pick < 82) begin
        send_word(row(MODE_WRITE, rand_byte(), rand_byte(),
                      rand_byte(), rand_bit(), rand_bit(),
                      1'b0, '0));
      end else if (pick < 92) begin
        send_word(row(MODE_HASH, rand_byte(), rand_byte(),
                      rand_byte(), rand_bit(), rand_bit(),
                      1'b0, '0));
      end else begin
        // A message that never reaches its last byte.
        len = $urandom_range(1, 6);
        for (int b = 0; b < len; b++)
          send_word(row(MODE_HASH, rand_byte(), rand_byte(),
                        rand_byte(), b == 0, 1'b0, 1'b0, '0));
      end
    end

    // Wind down: wait for the last digests, then a quiet tail before the final check.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_digests.size() != 0) begin
      $display("%0t: %0d digests never arrived", $time, pending_digests.size());
      errors++;
    end

    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- pearson_hash_64.f -----
sv/phash_pkg.sv
sv/phash_front.sv
sv/phash_back.sv
sv/pearson_hash_64.sv
tb/tb.sv
